@@ sv/tss_pkg.sv @@
// Shared types, register indexes and the glyph ramp of the torus shader.
package tss_pkg;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NX, ST_NY, ST_MPX, ST_MPY, ST_MPZ, ST_TMUL, ST_TACC,
    ST_SQA, ST_SQB, ST_SQC, ST_RTA, ST_SQD, ST_SQE, ST_SQF, ST_RTB,
    ST_NSQA, ST_NSQB, ST_NSQC, ST_NSQD, ST_NRT, ST_MK, ST_KDIV, ST_LDIV, ST_FIN
  } tss_state_t;

  typedef enum logic {IT_SQRT, IT_DIV} it_mode_t;

  typedef struct packed {
    logic     start;
    it_mode_t mode;
  } it_req_t;

  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_ROT_ROW_ZERO  = 3'd2;
  localparam logic [2:0] CFG_ROT_ROW_ONE   = 3'd3;
  localparam logic [2:0] CFG_ROT_ROW_TWO   = 3'd4;

  localparam logic [6:0] GLYPH_MISS = 7'h20;
  localparam logic [6:0] GLYPH_FLAT = 7'h2E;
  localparam logic [6:0] RAMP_LAST  = 7'd68;
  localparam int         RAMP_LEN   = 69;

  localparam logic [6:0] RAMP [0:68] = '{
    7'h40, 7'h57, 7'h4D, 7'h42, 7'h24, 7'h25, 7'h38, 7'h26, 7'h23, 7'h2A,
    7'h6F, 7'h61, 7'h68, 7'h6B, 7'h62, 7'h64, 7'h70, 7'h71, 7'h77, 7'h6D,
    7'h5A, 7'h4F, 7'h30, 7'h51, 7'h4C, 7'h43, 7'h4A, 7'h55, 7'h59, 7'h58,
    7'h7A, 7'h63, 7'h76, 7'h75, 7'h6E, 7'h78, 7'h72, 7'h6A, 7'h66, 7'h74,
    7'h2F, 7'h5C, 7'h7C, 7'h28, 7'h29, 7'h31, 7'h7B, 7'h7D, 7'h5B, 7'h5D,
    7'h3F, 7'h2D, 7'h5F, 7'h2B, 7'h7E, 7'h3C, 7'h3E, 7'h69, 7'h21, 7'h6C,
    7'h49, 7'h3B, 7'h3A, 7'h2C, 7'h22, 7'h5E, 7'h60, 7'h27, 7'h2E
  };

  // signed Q2.14 matrix entry j of a packed row
  function automatic logic signed [15:0] rot_ent(input logic [47:0] row,
                                                  input logic [1:0] j);
    logic signed [15:0] e;
    case (j)
      2'd0:    e = row[15:0];
      2'd1:    e = row[31:16];
      2'd2:    e = row[47:32];
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

@@ sv/tss_mul.sv @@
// Shared multiplier: registered magnitude product plus rounded, saturated shift.
module tss_mul #(
  parameter int W = 24,
  parameter int F = 16
) (
  input  logic                      clk,
  input  logic                      go,
  input  logic                      sh14,
  input  logic signed [W+1:0]       a,
  input  logic signed [W+1:0]       b,
  output logic        [2*W+3:0]     prod,
  output logic signed [W-1:0]       rnd
);
  localparam int AW = W + 2;
  localparam int PW = 2 * AW;

  logic [AW-1:0] ma, mb;
  logic [PW-1:0] prod_r;
  logic          neg_r, sh14_r;
  logic [PW:0]   rs, m;

  localparam logic [PW:0] HI  = ((PW+1)'(1) << (W-1)) - (PW+1)'(1);
  localparam logic [PW:0] LIM = (PW+1)'(1) << (W-1);

  assign ma = a[AW-1] ? AW'(-a) : AW'(a);
  assign mb = b[AW-1] ? AW'(-b) : AW'(b);

  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= ma * mb;
      neg_r  <= a[AW-1] ^ b[AW-1];
      sh14_r <= sh14;
    end
  end

  always_comb begin
    rs = {1'b0, prod_r} + (sh14_r ? ((PW+1)'(1) << 13) : ((PW+1)'(1) << (F-1)));
    m  = sh14_r ? (rs >> 14) : (rs >> F);
    if (!neg_r) begin
      rnd = (m > HI) ? W'(HI) : W'(m);
    end else begin
      rnd = (m > LIM) ? W'(LIM) : -W'(m);
    end
  end

  assign prod = prod_r;

endmodule

@@ sv/tss_iter.sv @@
// Shared iterative unit: bit-serial square root or restoring division.
module tss_iter #(
  parameter int W  = 24,
  parameter int NW = 42
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tss_pkg::it_req_t     req,
  input  logic [2*W-1:0]       rad,
  input  logic [NW-1:0]        dvd,
  input  logic [W-1:0]         dvs,
  output logic                 done,
  output logic [W-1:0]         root,
  output logic [NW-1:0]        quo
);
  localparam int OPW = (2 * W > NW) ? 2 * W : NW;
  localparam int CW  = $clog2(OPW + 1);

  tss_pkg::it_mode_t mode_r;
  logic              busy_r, done_r;
  logic [CW-1:0]     cnt_r;
  logic [OPW-1:0]    opnd_r;
  logic [W:0]        rem_r;
  logic [NW-1:0]     res_r;
  logic [W-1:0]      dvs_r;

  logic [W+2:0]      s_rs, s_trial;
  logic [W:0]        d_rs;
  logic [W:0]        rem_nxt;
  logic [NW-1:0]     res_nxt;
  logic [OPW-1:0]    opnd_nxt;
  logic [CW-1:0]     last;

  always_comb begin
    s_rs    = {rem_r, opnd_r[OPW-1 -: 2]};
    s_trial = {1'b0, res_r[W-1:0], 2'b01};
    d_rs    = {rem_r[W-1:0], opnd_r[OPW-1]};
    if (mode_r == tss_pkg::IT_SQRT) begin
      last     = CW'(W - 1);
      opnd_nxt = opnd_r << 2;
      if (s_rs >= s_trial) begin
        rem_nxt = (W+1)'(s_rs - s_trial);
        res_nxt = {res_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = (W+1)'(s_rs);
        res_nxt = {res_r[NW-2:0], 1'b0};
      end
    end else begin
      last     = CW'(NW - 1);
      opnd_nxt = opnd_r << 1;
      if (d_rs >= {1'b0, dvs_r}) begin
        rem_nxt = d_rs - {1'b0, dvs_r};
        res_nxt = {res_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = d_rs;
        res_nxt = {res_r[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mode_r <= req.mode;
        rem_r  <= '0;
        res_r  <= '0;
        dvs_r  <= dvs;
        if (req.mode == tss_pkg::IT_SQRT) begin
          opnd_r <= OPW'(rad) << (OPW - 2 * W);
        end else begin
          opnd_r <= OPW'(dvd) << (OPW - NW);
        end
      end else if (busy_r) begin
        opnd_r <= opnd_nxt;
        rem_r  <= rem_nxt;
        res_r  <= res_nxt;
        cnt_r  <= cnt_r + CW'(1);
        if (cnt_r == last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[W-1:0];
  assign quo  = res_r;

endmodule

@@ sv/torus_sphere_trace_shader.sv @@
// Torus sphere-trace shader: one pixel in, one ASCII glyph out, one item at a time.
// Each item runs two coordinate divisions, then march steps (15 products and two
// square roots on the shared multiplier and root/divide unit), six distance passes
// and a final root and division for shading. The next item is accepted once the
// glyph is in the output register. Reset is synchronous.
module torus_sphere_trace_shader #(
  parameter int MAX_STEPS = 100,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  in_pix_x,
  input  logic [9:0]  in_pix_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_glyph,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  localparam int W   = FRAC_BITS + 8;   // Q8.F value width
  localparam int AW  = W + 2;           // multiplier operand width
  localparam int NW  = W + FRAC_BITS + 2;
  localparam int SW  = NW + 2;          // headroom for pre-saturation sums
  localparam int STW = $clog2(MAX_STEPS + 1);
  localparam int XW  = FRAC_BITS + 1;
  localparam int IW  = FRAC_BITS + 8;

  localparam int ONE_L = 1 << FRAC_BITS;
  localparam int EPS_L = (ONE_L + 500) / 1000;
  localparam logic signed [W-1:0] ONE_V  = W'(ONE_L);
  localparam logic signed [W-1:0] TWO_V  = W'(2 * ONE_L);
  localparam logic signed [W-1:0] HALF_V = W'(ONE_L / 2);
  localparam logic signed [W-1:0] Z0_V   = W'(7 * (ONE_L / 2));
  localparam logic signed [W-1:0] EPS_V  = W'(EPS_L);
  localparam logic signed [W-1:0] FAR_V  = W'(100 * ONE_L);
  localparam logic signed [SW-1:0] HI_X  = (SW'(1) <<< (W-1)) - SW'(1);
  localparam logic signed [SW-1:0] LO_X  = -(SW'(1) <<< (W-1));

  // floor(sqrt(2^(2F)/3)) for normalizing against the light vector
  function automatic longint k_of(input int f);
    longint v, r, b;
    v = (64'sd1 <<< (2 * f)) / 3;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - r - b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  localparam longint K_L = k_of(FRAC_BITS);
  localparam logic signed [AW-1:0] K_V = AW'(K_L);

  function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
    if (v > HI_X) return W'(HI_X);
    if (v < LO_X) return W'(LO_X);
    return W'(v);
  endfunction

  // configuration
  logic [10:0] width_r, height_r;
  logic [47:0] rot_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd120;
      height_r <= 11'd30;
      rot_r[0] <= 48'd1073741824;
      rot_r[1] <= 48'd16384;
      rot_r[2] <= 48'd70368744177664;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tss_pkg::CFG_SCREEN_WIDTH:  width_r  <= cfg_data[10:0];
        tss_pkg::CFG_SCREEN_HEIGHT: height_r <= cfg_data[10:0];
        tss_pkg::CFG_ROT_ROW_ZERO:  rot_r[0] <= cfg_data;
        tss_pkg::CFG_ROT_ROW_ONE:   rot_r[1] <= cfg_data;
        tss_pkg::CFG_ROT_ROW_TWO:   rot_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  tss_pkg::tss_state_t state_r, state_nxt;
  logic signed [W-1:0]  cx_r, cx_nxt, cy_r, cy_nxt, t_r, t_nxt;
  logic signed [W-1:0]  p_r [3], p_nxt [3];
  logic signed [W-1:0]  pt_r [3], pt_nxt [3];
  logic signed [W-1:0]  q_r [3], q_nxt [3];
  logic signed [W-1:0]  n_r [3], n_nxt [3];
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [W-1:0]  ring_r, ring_nxt, dhi_r, dhi_nxt;
  logic [2*W-1:0]       ss_r, ss_nxt;
  logic [W-1:0]         len_r, len_nxt;
  logic [STW-1:0]       step_r, step_nxt;
  logic [1:0]           i_r, i_nxt, j_r, j_nxt, ax_r, ax_nxt;
  logic                 lo_r, lo_nxt, shd_r, shd_nxt;
  logic [9:0]           pix_y_r, pix_y_nxt;
  logic [6:0]           gl_r, gl_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [6:0]           out_glyph_r, out_glyph_nxt;

  // shared units
  logic                 mul_go, mul_sh14;
  logic signed [AW-1:0] mul_a, mul_b;
  logic [2*AW-1:0]      mul_prod;
  logic signed [W-1:0]  mul_rnd;
  tss_pkg::it_req_t     it_req;
  logic [2*W-1:0]       it_rad;
  logic [NW-1:0]        it_dvd;
  logic [W-1:0]         it_dvs;
  logic                 it_done;
  logic [W-1:0]         it_root;
  logic [NW-1:0]        it_quo;

  tss_mul #(.W(W), .F(FRAC_BITS)) u_mul (
    .clk  (clk),
    .go   (mul_go),
    .sh14 (mul_sh14),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod),
    .rnd  (mul_rnd)
  );

  tss_iter #(.W(W), .NW(NW)) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (it_req),
    .rad   (it_rad),
    .dvd   (it_dvd),
    .dvs   (it_dvs),
    .done  (it_done),
    .root  (it_root),
    .quo   (it_quo)
  );

  // derived values
  logic                 in_acc;
  logic signed [W-1:0]  norm_v, root_sat, dval;
  logic                 hit, past_far, last_step;
  logic signed [AW-1:0] num_v;
  logic                 flat;
  logic [10:0]          wsize, hsize;
  logic [XW-1:0]        dark;
  logic [IW-1:0]        idx_full;
  logic [7:0]           idx8;
  logic [6:0]           lit_glyph;

  assign in_stall = (state_r != tss_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wsize    = (width_r == '0) ? 11'd1 : width_r;
  assign hsize    = (height_r == '0) ? 11'd1 : height_r;

  assign norm_v    = sat($signed(SW'({1'b0, it_quo})) - SW'(ONE_V));
  assign root_sat  = sat($signed(SW'({1'b0, it_root})));
  assign dval      = sat(SW'(root_sat) - SW'(HALF_V));
  assign hit       = dval < EPS_V;
  assign past_far  = t_r > FAR_V;
  assign last_step = (step_r == STW'(MAX_STEPS - 1));
  assign num_v     = AW'(n_r[2]) - AW'(n_r[0]) - AW'(n_r[1]);
  assign flat      = (num_v <= 0) || (it_root == '0);

  // light = num*K/len; index is floor((1 - light) * 69), capped
  always_comb begin
    dark      = XW'(ONE_L) - it_quo[XW-1:0];
    idx_full  = IW'(dark) * IW'(tss_pkg::RAMP_LEN);
    idx8      = idx_full[IW-1:FRAC_BITS];
    if (it_quo >= NW'(ONE_L)) begin
      lit_glyph = tss_pkg::RAMP[0];
    end else if (idx8 > 8'(tss_pkg::RAMP_LAST)) begin
      lit_glyph = tss_pkg::RAMP[tss_pkg::RAMP_LAST];
    end else begin
      lit_glyph = tss_pkg::RAMP[idx8[6:0]];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tss_pkg::ST_IDLE: if (in_acc) state_nxt = tss_pkg::ST_NX;
      tss_pkg::ST_NX:   if (it_done) state_nxt = tss_pkg::ST_NY;
      tss_pkg::ST_NY:   if (it_done) state_nxt = tss_pkg::ST_MPX;
      tss_pkg::ST_MPX:  state_nxt = tss_pkg::ST_MPY;
      tss_pkg::ST_MPY:  state_nxt = tss_pkg::ST_MPZ;
      tss_pkg::ST_MPZ:  state_nxt = tss_pkg::ST_TMUL;
      tss_pkg::ST_TMUL: state_nxt = tss_pkg::ST_TACC;
      tss_pkg::ST_TACC: begin
        if (j_r == 2'd2 && i_r == 2'd2) state_nxt = tss_pkg::ST_SQA;
        else                            state_nxt = tss_pkg::ST_TMUL;
      end
      tss_pkg::ST_SQA:  state_nxt = tss_pkg::ST_SQB;
      tss_pkg::ST_SQB:  state_nxt = tss_pkg::ST_SQC;
      tss_pkg::ST_SQC:  state_nxt = tss_pkg::ST_RTA;
      tss_pkg::ST_RTA:  if (it_done) state_nxt = tss_pkg::ST_SQD;
      tss_pkg::ST_SQD:  state_nxt = tss_pkg::ST_SQE;
      tss_pkg::ST_SQE:  state_nxt = tss_pkg::ST_SQF;
      tss_pkg::ST_SQF:  state_nxt = tss_pkg::ST_RTB;
      tss_pkg::ST_RTB: begin
        if (it_done) begin
          if (!shd_r) begin
            if (hit)                         state_nxt = tss_pkg::ST_TMUL;
            else if (past_far || last_step)  state_nxt = tss_pkg::ST_FIN;
            else                             state_nxt = tss_pkg::ST_MPX;
          end else if (lo_r && ax_r == 2'd2) begin
            state_nxt = tss_pkg::ST_NSQA;
          end else begin
            state_nxt = tss_pkg::ST_TMUL;
          end
        end
      end
      tss_pkg::ST_NSQA: state_nxt = tss_pkg::ST_NSQB;
      tss_pkg::ST_NSQB: state_nxt = tss_pkg::ST_NSQC;
      tss_pkg::ST_NSQC: state_nxt = tss_pkg::ST_NSQD;
      tss_pkg::ST_NSQD: state_nxt = tss_pkg::ST_NRT;
      tss_pkg::ST_NRT: begin
        if (it_done) state_nxt = flat ? tss_pkg::ST_FIN : tss_pkg::ST_MK;
      end
      tss_pkg::ST_MK:   state_nxt = tss_pkg::ST_KDIV;
      tss_pkg::ST_KDIV: state_nxt = tss_pkg::ST_LDIV;
      tss_pkg::ST_LDIV: if (it_done) state_nxt = tss_pkg::ST_FIN;
      tss_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = tss_pkg::ST_IDLE;
      end
      default: state_nxt = tss_pkg::ST_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    mul_go   = 1'b0;
    mul_sh14 = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    it_req   = '{start: 1'b0, mode: tss_pkg::IT_DIV};
    it_rad   = ss_r + mul_prod[2*W-1:0];
    it_dvd   = NW'(in_pix_x) << (FRAC_BITS + 1);
    it_dvs   = W'(wsize);
    unique case (state_r)
      tss_pkg::ST_IDLE: it_req.start = in_acc;
      tss_pkg::ST_NX: begin
        it_req.start = it_done;
        it_dvd       = NW'(pix_y_r) << (FRAC_BITS + 1);
        it_dvs       = W'(hsize);
      end
      tss_pkg::ST_MPX: begin
        mul_go = 1'b1; mul_a = AW'(cx_r); mul_b = AW'(t_r);
      end
      tss_pkg::ST_MPY: begin
        mul_go = 1'b1; mul_a = AW'(cy_r); mul_b = AW'(t_r);
      end
      tss_pkg::ST_TMUL: begin
        mul_go   = 1'b1;
        mul_sh14 = 1'b1;
        mul_a    = AW'(tss_pkg::rot_ent(rot_r[i_r], j_r));
        mul_b    = AW'(pt_r[j_r]);
      end
      tss_pkg::ST_SQA:  begin mul_go = 1'b1; mul_a = AW'(q_r[0]); mul_b = AW'(q_r[0]); end
      tss_pkg::ST_SQB:  begin mul_go = 1'b1; mul_a = AW'(q_r[2]); mul_b = AW'(q_r[2]); end
      tss_pkg::ST_SQD:  begin mul_go = 1'b1; mul_a = AW'(ring_r); mul_b = AW'(ring_r); end
      tss_pkg::ST_SQE:  begin mul_go = 1'b1; mul_a = AW'(q_r[1]); mul_b = AW'(q_r[1]); end
      tss_pkg::ST_NSQA: begin mul_go = 1'b1; mul_a = AW'(n_r[0]); mul_b = AW'(n_r[0]); end
      tss_pkg::ST_NSQB: begin mul_go = 1'b1; mul_a = AW'(n_r[1]); mul_b = AW'(n_r[1]); end
      tss_pkg::ST_NSQC: begin mul_go = 1'b1; mul_a = AW'(n_r[2]); mul_b = AW'(n_r[2]); end
      tss_pkg::ST_SQC, tss_pkg::ST_SQF, tss_pkg::ST_NSQD: begin
        it_req = '{start: 1'b1, mode: tss_pkg::IT_SQRT};
      end
      tss_pkg::ST_MK: begin
        mul_go = 1'b1; mul_a = num_v; mul_b = K_V;
      end
      tss_pkg::ST_KDIV: begin
        it_req.start = 1'b1;
        it_dvd       = mul_prod[NW-1:0];
        it_dvs       = len_r;
      end
      default: ;
    endcase
  end

  // datapath updates
  always_comb begin
    cx_nxt = cx_r; cy_nxt = cy_r; t_nxt = t_r;
    p_nxt = p_r; pt_nxt = pt_r; q_nxt = q_r; n_nxt = n_r;
    acc_nxt = acc_r; ring_nxt = ring_r; dhi_nxt = dhi_r;
    ss_nxt = ss_r; len_nxt = len_r; step_nxt = step_r;
    i_nxt = i_r; j_nxt = j_r; ax_nxt = ax_r; lo_nxt = lo_r; shd_nxt = shd_r;
    pix_y_nxt = pix_y_r; gl_nxt = gl_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_glyph_nxt = out_glyph_r;
    unique case (state_r)
      tss_pkg::ST_IDLE: if (in_acc) pix_y_nxt = in_pix_y;
      tss_pkg::ST_NX:   if (it_done) cx_nxt = norm_v;
      tss_pkg::ST_NY: begin
        if (it_done) begin
          cy_nxt   = norm_v;
          t_nxt    = '0;
          step_nxt = '0;
        end
      end
      tss_pkg::ST_MPY: begin
        p_nxt[0]  = mul_rnd;
        pt_nxt[0] = mul_rnd;
      end
      tss_pkg::ST_MPZ: begin
        p_nxt[1]  = mul_rnd;
        pt_nxt[1] = mul_rnd;
        p_nxt[2]  = sat(SW'(Z0_V) - SW'(t_r));
        pt_nxt[2] = sat(SW'(Z0_V) - SW'(t_r));
        i_nxt = '0; j_nxt = '0; acc_nxt = '0; shd_nxt = 1'b0;
      end
      tss_pkg::ST_TACC: begin
        if (j_r == 2'd2) begin
          q_nxt[i_r] = sat(SW'(acc_r) + SW'(mul_rnd));
          acc_nxt    = '0;
          j_nxt      = '0;
          i_nxt      = (i_r == 2'd2) ? 2'd0 : i_r + 2'd1;
        end else begin
          acc_nxt = acc_r + AW'(mul_rnd);
          j_nxt   = j_r + 2'd1;
        end
      end
      tss_pkg::ST_SQB, tss_pkg::ST_SQE, tss_pkg::ST_NSQB: ss_nxt = mul_prod[2*W-1:0];
      tss_pkg::ST_NSQC: ss_nxt = ss_r + mul_prod[2*W-1:0];
      tss_pkg::ST_RTA: if (it_done) ring_nxt = sat(SW'(root_sat) - SW'(TWO_V));
      tss_pkg::ST_RTB: begin
        if (it_done) begin
          if (!shd_r) begin
            if (hit) begin
              // start the normal: +eps on x first
              shd_nxt   = 1'b1;
              ax_nxt    = '0;
              lo_nxt    = 1'b0;
              pt_nxt    = p_r;
              pt_nxt[0] = sat(SW'(p_r[0]) + SW'(EPS_V));
            end else if (past_far) begin
              gl_nxt = tss_pkg::GLYPH_MISS;
            end else begin
              t_nxt    = sat(SW'(t_r) + SW'(dval));
              step_nxt = step_r + STW'(1);
              gl_nxt   = tss_pkg::GLYPH_MISS;
            end
          end else if (!lo_r) begin
            dhi_nxt        = dval;
            lo_nxt         = 1'b1;
            pt_nxt         = p_r;
            pt_nxt[ax_r]   = sat(SW'(p_r[ax_r]) - SW'(EPS_V));
          end else begin
            n_nxt[ax_r] = sat(SW'(dhi_r) - SW'(dval));
            lo_nxt      = 1'b0;
            if (ax_r != 2'd2) begin
              ax_nxt             = ax_r + 2'd1;
              pt_nxt             = p_r;
              pt_nxt[ax_r + 2'd1] = sat(SW'(p_r[ax_r + 2'd1]) + SW'(EPS_V));
            end
          end
        end
      end
      tss_pkg::ST_NRT: begin
        if (it_done) begin
          len_nxt = it_root;
          gl_nxt  = tss_pkg::GLYPH_FLAT;
        end
      end
      tss_pkg::ST_LDIV: if (it_done) gl_nxt = lit_glyph;
      tss_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_glyph_nxt = gl_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tss_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt; cy_r <= cy_nxt; t_r <= t_nxt;
    p_r <= p_nxt; pt_r <= pt_nxt; q_r <= q_nxt; n_r <= n_nxt;
    acc_r <= acc_nxt; ring_r <= ring_nxt; dhi_r <= dhi_nxt;
    ss_r <= ss_nxt; len_r <= len_nxt; step_r <= step_nxt;
    i_r <= i_nxt; j_r <= j_nxt; ax_r <= ax_nxt; lo_r <= lo_nxt; shd_r <= shd_nxt;
    pix_y_r <= pix_y_nxt; gl_r <= gl_nxt;
    out_glyph_r <= out_glyph_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_glyph = out_glyph_r;

endmodule
